// ===== hw/rtl/wsd_pkg.sv =====
// Shared types for the websocket frame deframer.
// No dependencies; imported by wsd_utf8, wsd_parser and the top level.
`default_nettype none

package wsd_pkg;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic       last;
        logic [7:0] data;
    } utf_ctl_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_utf8.sv =====
// Streaming UTF-8 checker for final text frame payloads.
// Depends on wsd_pkg (utf_ctl_t).
`default_nettype none

module wsd_utf8 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wsd_pkg::utf_ctl_t ctl,
    output logic                   bad
);
    import wsd_pkg::*;

    logic [1:0]  need_reg, need_next;
    logic [2:0]  len_reg, len_next;
    logic [20:0] code_reg, code_next;
    logic        seq_bad;

    always_comb
    begin
        need_next = need_reg;
        len_next  = len_reg;
        code_next = code_reg;
        seq_bad   = 1'b0;
        if (need_reg == 2'd0)
        begin
            if (ctl.data[7] == 1'b0)
            begin
                seq_bad = 1'b0;
            end
            else if (ctl.data[7:5] == 3'b110)
            begin
                code_next = {16'd0, ctl.data[4:0]};
                need_next = 2'd1;
                len_next  = 3'd2;
            end
            else if (ctl.data[7:4] == 4'b1110)
            begin
                code_next = {17'd0, ctl.data[3:0]};
                need_next = 2'd2;
                len_next  = 3'd3;
            end
            else if (ctl.data[7:3] == 5'b11110)
            begin
                code_next = {18'd0, ctl.data[2:0]};
                need_next = 2'd3;
                len_next  = 3'd4;
            end
            else
            begin
                seq_bad = 1'b1;
            end
        end
        else if (ctl.data[7:6] != 2'b10)
        begin
            seq_bad = 1'b1;
        end
        else
        begin
            code_next = {code_reg[14:0], ctl.data[5:0]};
            need_next = need_reg - 2'd1;
            if (need_next == 2'd0)
            begin
                case (len_reg)
                    3'd2:    seq_bad = code_next < 21'h80;
                    3'd3:    seq_bad = (code_next < 21'h800) ||
                                       ((code_next >= 21'hD800) && (code_next <= 21'hDFFF));
                    default: seq_bad = (code_next < 21'h10000) || (code_next > 21'h10FFFF);
                endcase
            end
        end
        bad = ctl.step && (seq_bad || (ctl.last && (need_next != 2'd0)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 2'd0;
            len_reg  <= 3'd0;
            code_reg <= 21'd0;
        end
        else if (ctl.clear)
        begin
            need_reg <= 2'd0;
            len_reg  <= 3'd0;
            code_reg <= 21'd0;
        end
        else if (ctl.step)
        begin
            need_reg <= need_next;
            len_reg  <= len_next;
            code_reg <= code_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_parser.sv =====
// Frame header parser, length and key collection, payload unmasking.
// Depends on wsd_pkg (utf_ctl_t, res_t) and wsd_utf8.
`default_nettype none

module wsd_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  in_byte,
    input  wire logic        server_mode,
    output wsd_pkg::res_t    res
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_RSV       = 3'd1;
    localparam logic [2:0] ERR_OPCODE    = 3'd2;
    localparam logic [2:0] ERR_CTRL_FRAG = 3'd3;
    localparam logic [2:0] ERR_MASK_REQ  = 3'd4;
    localparam logic [2:0] ERR_MASK_BAD  = 3'd5;
    localparam logic [2:0] ERR_CTRL_BIG  = 3'd6;
    localparam logic [2:0] ERR_UTF8      = 3'd7;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0]  LEN_EXT16    = 7'd126;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] length_reg, length_next;
    logic [63:0] payload_left_reg, payload_left_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_idx_reg, key_idx_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic        masked_reg, masked_next;
    logic [2:0]  err_reg, err_next;

    logic [63:0] len_val;
    logic [3:0]  op;
    logic [7:0]  key_byte;
    logic [7:0]  out_byte;
    logic        len_done;
    logic        utf_bad;
    logic        emit;
    utf_ctl_t    utf_ctl;

    wsd_utf8 u_utf8 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (utf_ctl),
        .bad   (utf_bad)
    );

    assign op = in_byte[3:0];

    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        ext_left_next     = ext_left_reg;
        length_next       = length_reg;
        payload_left_next = payload_left_reg;
        key_next          = key_reg;
        key_idx_next      = key_idx_reg;
        opcode_next       = opcode_reg;
        fin_next          = fin_reg;
        masked_next       = masked_reg;
        err_next          = err_reg;
        out_byte          = in_byte;
        emit              = 1'b0;
        len_done          = 1'b0;
        len_val           = (phase_reg == PH_EXT) ? {length_reg[55:0], in_byte}
                                                  : {57'd0, in_byte[6:0]};
        utf_ctl.step      = 1'b0;
        utf_ctl.clear     = 1'b0;
        utf_ctl.last      = (payload_left_reg == 64'd1);
        utf_ctl.data      = in_byte;

        if (step && (err_reg == ERR_NONE))
        begin
            emit = 1'b1;
            case (phase_reg)
                PH_HDR1:
                begin
                    if (in_byte[6:4] != 3'd0)
                    begin
                        err_next = ERR_RSV;
                    end
                    else if ((op > OP_PONG) || ((op > OP_BIN) && (op < OP_CLOSE)))
                    begin
                        err_next = ERR_OPCODE;
                    end
                    else if (op[3] && !in_byte[7])
                    begin
                        err_next = ERR_CTRL_FRAG;
                    end
                    else
                    begin
                        opcode_next = op;
                        fin_next    = in_byte[7];
                        phase_next  = PH_HDR2;
                    end
                end
                PH_HDR2:
                begin
                    masked_next = in_byte[7];
                    if (server_mode && !in_byte[7])
                    begin
                        err_next = ERR_MASK_REQ;
                    end
                    else if (!server_mode && in_byte[7])
                    begin
                        err_next = ERR_MASK_BAD;
                    end
                    else if (in_byte[6:0] < LEN_EXT16)
                    begin
                        length_next = len_val;
                        len_done    = 1'b1;
                    end
                    else
                    begin
                        length_next   = 64'd0;
                        ext_left_next = (in_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                        phase_next    = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    length_next   = len_val;
                    ext_left_next = ext_left_reg - 4'd1;
                    len_done      = (ext_left_next == 4'd0);
                end
                PH_KEY:
                begin
                    key_next      = {key_reg[23:0], in_byte};
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_next == 4'd0)
                    begin
                        key_idx_next  = 2'd0;
                        utf_ctl.clear = 1'b1;
                        phase_next    = (payload_left_reg == 64'd0) ? PH_HDR1 : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (masked_reg)
                    begin
                        out_byte = in_byte ^ key_byte;
                    end
                    utf_ctl.data      = out_byte;
                    key_idx_next      = key_idx_reg + 2'd1;
                    payload_left_next = payload_left_reg - 64'd1;
                    if ((opcode_reg == OP_TEXT) && fin_reg)
                    begin
                        utf_ctl.step = 1'b1;
                        if (utf_bad)
                        begin
                            err_next = ERR_UTF8;
                        end
                    end
                    if (utf_ctl.last)
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase

            if (len_done)
            begin
                if (opcode_reg[3] && (len_val > CTRL_MAX_LEN))
                begin
                    err_next = ERR_CTRL_BIG;
                end
                else
                begin
                    payload_left_next = len_val;
                    if (masked_next)
                    begin
                        ext_left_next = 4'd4;
                        phase_next    = PH_KEY;
                    end
                    else
                    begin
                        key_idx_next  = 2'd0;
                        utf_ctl.clear = 1'b1;
                        phase_next    = (len_val == 64'd0) ? PH_HDR1 : PH_DATA;
                    end
                end
            end

            if (err_next != ERR_NONE)
            begin
                emit = 1'b0;
            end
        end

        res.emit = emit;
        res.data = out_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR1;
            ext_left_reg     <= 4'd0;
            length_reg       <= 64'd0;
            payload_left_reg <= 64'd0;
            key_reg          <= 32'd0;
            key_idx_reg      <= 2'd0;
            opcode_reg       <= 4'd0;
            fin_reg          <= 1'b0;
            masked_reg       <= 1'b0;
            err_reg          <= ERR_NONE;
        end
        else
        begin
            phase_reg        <= phase_next;
            ext_left_reg     <= ext_left_next;
            length_reg       <= length_next;
            payload_left_reg <= payload_left_next;
            key_reg          <= key_next;
            key_idx_reg      <= key_idx_next;
            opcode_reg       <= opcode_next;
            fin_reg          <= fin_next;
            masked_reg       <= masked_next;
            err_reg          <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |=> (err_reg == $past(err_reg)))
        else $error("sticky error changed");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |-> !res.emit)
        else $error("beat emitted while in error");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (payload_left_reg != 64'd0))
        else $error("payload phase with nothing left");

    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KEY) |-> (masked_reg && (ext_left_reg != 4'd0) &&
                                   (ext_left_reg <= 4'd4)))
        else $error("bad key byte count");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// Top level of the websocket frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_parser and wsd_utf8.
//
//  channel  | direction | signals                    | beat
//  s_*      | in        | s_tvalid s_tready s_tdata  | one received byte
//  m_*      | out       | m_tvalid m_tready m_tdata  | header byte or unmasked payload byte
//  cfg_*    | in        | cfg_valid cfg_ready cfg_data | server_mode write
//
// Each byte is parsed from the input register in the cycle proc_fire is high and lands in the
// result register at the next edge; one byte per cycle is sustained while m_tready stays high,
// as the parser updates its state on every accepted byte.
// Reset: rst_n clears all control state (the data registers are not reset); server_mode resets to 1. No clearing pass.
// Stalls: m_tready low holds the result register and backs up into s_tready.
// Error bytes and all bytes after an error are consumed with no output beat.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [0:0] cfg_data   // [0] server_mode
);
    import wsd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       server_mode_reg;
    logic       proc_fire;
    res_t       res;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_byte_reg;
    assign cfg_ready = 1'b1;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (proc_fire),
        .in_byte     (in_byte_reg),
        .server_mode (server_mode_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            server_mode_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && res.emit)
        begin
            out_byte_reg <= res.data;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !proc_fire)
        else $error("parser stepped into a stalled result");

    a_fill_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && res.emit) |=> out_valid_reg)
        else $error("emitted beat not captured");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");
`endif

endmodule

`default_nettype wire

// ===== dv/websocket_frame_deframer_tb.sv =====
// Self-checking testbench for websocket_frame_deframer: directed and random frame streams,
// predicted byte for byte by an in-bench tracker of the frame parser and UTF-8 checker.
// Depends only on the RTL of the block.
`default_nettype none

module websocket_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;
    localparam int         CTRL_MAX_LEN = 125;

    localparam int FORM_7  = 0;
    localparam int FORM_16 = 1;
    localparam int FORM_64 = 2;

    typedef enum logic [2:0] {
        ST_FIRST,
        ST_LEN,
        ST_EXTLEN,
        ST_KEY,
        ST_PAYLOAD
    } hdr_state_t;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_RSV,
        FAULT_OPCODE,
        FAULT_CTRL_FRAG,
        FAULT_MASK_MISSING,
        FAULT_MASK_UNEXPECTED,
        FAULT_CTRL_LONG,
        FAULT_UTF8
    } fault_t;

    class deframe_tracker;
        logic        server_mode;
        hdr_state_t  st;
        logic [3:0]  ext_left;
        logic [63:0] len_acc;
        logic [63:0] left;
        logic [31:0] key;
        logic [1:0]  key_idx;
        logic [3:0]  opcode;
        logic        fin;
        logic        masked;
        logic [1:0]  utf_need;
        logic [2:0]  utf_len;
        logic [20:0] utf_code;
        fault_t      fault;
        logic [7:0]  due_bytes[$];
        int          bad_count;

        function new();
            server_mode = 1'b1;
            st          = ST_FIRST;
            ext_left    = '0;
            len_acc     = '0;
            left        = '0;
            key         = '0;
            key_idx     = '0;
            opcode      = '0;
            fin         = 1'b0;
            masked      = 1'b0;
            utf_need    = '0;
            utf_len     = '0;
            utf_code    = '0;
            fault       = FAULT_NONE;
            bad_count   = 0;
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction

        function void start_payload();
            key_idx  = '0;
            utf_need = '0;
            utf_len  = '0;
            utf_code = '0;
            st       = (left == 0) ? ST_FIRST : ST_PAYLOAD;
        endfunction

        function bit close_length();
            if (opcode >= OP_CLOSE && len_acc > CTRL_MAX_LEN)
            begin
                fault = FAULT_CTRL_LONG;
                return 1'b0;
            end
            left = len_acc;
            if (masked)
            begin
                ext_left = 4'd4;
                st       = ST_KEY;
            end
            else
            begin
                start_payload();
            end
            return 1'b1;
        endfunction

        function bit utf_step(input logic [7:0] c);
            if (utf_need == 0)
            begin
                if (c <= 8'h7F) return 1'b1;
                if ((c & 8'hE0) == 8'hC0)
                begin
                    utf_code = {16'd0, c[4:0]};
                    utf_need = 2'd1;
                    utf_len  = 3'd2;
                    return 1'b1;
                end
                if ((c & 8'hF0) == 8'hE0)
                begin
                    utf_code = {17'd0, c[3:0]};
                    utf_need = 2'd2;
                    utf_len  = 3'd3;
                    return 1'b1;
                end
                if ((c & 8'hF8) == 8'hF0)
                begin
                    utf_code = {18'd0, c[2:0]};
                    utf_need = 2'd3;
                    utf_len  = 3'd4;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (c[7:6] != 2'b10) return 1'b0;
            utf_code = {utf_code[14:0], c[5:0]};
            utf_need = utf_need - 2'd1;
            if (utf_need != 0) return 1'b1;
            if (utf_len == 3'd2) return utf_code >= 21'h80;
            if (utf_len == 3'd3)
                return utf_code >= 21'h800 && !(utf_code >= 21'hD800 && utf_code <= 21'hDFFF);
            return utf_code >= 21'h10000 && utf_code <= 21'h10FFFF;
        endfunction

        function void take_in(input logic [7:0] b);
            logic [7:0] o;
            logic [6:0] len7;
            logic [3:0] op;
            o = b;
            if (fault != FAULT_NONE) return;
            case (st)
                ST_LEN:
                begin
                    len7   = b[6:0];
                    masked = b[7];
                    if (server_mode && !masked)
                    begin
                        fault = FAULT_MASK_MISSING;
                        return;
                    end
                    if (!server_mode && masked)
                    begin
                        fault = FAULT_MASK_UNEXPECTED;
                        return;
                    end
                    if (len7 < LEN_EXT16)
                    begin
                        len_acc = {57'd0, len7};
                        if (!close_length()) return;
                    end
                    else
                    begin
                        len_acc  = '0;
                        ext_left = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
                        st       = ST_EXTLEN;
                    end
                end
                ST_EXTLEN:
                begin
                    len_acc  = {len_acc[55:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 0 && !close_length()) return;
                end
                ST_KEY:
                begin
                    key      = {key[23:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 0) start_payload();
                end
                ST_PAYLOAD:
                begin
                    if (masked) o = b ^ key[8 * (3 - int'(key_idx)) +: 8];
                    key_idx = key_idx + 2'd1;
                    left    = left - 64'd1;
                    if (opcode == OP_TEXT && fin)
                    begin
                        if (!utf_step(o) || (left == 0 && utf_need != 0))
                        begin
                            fault = FAULT_UTF8;
                            return;
                        end
                    end
                    if (left == 0) st = ST_FIRST;
                end
                default:
                begin
                    op = b[3:0];
                    if (b[6:4] != 3'b000)
                    begin
                        fault = FAULT_RSV;
                        return;
                    end
                    if (op > OP_PONG || (op > OP_BIN && op < OP_CLOSE))
                    begin
                        fault = FAULT_OPCODE;
                        return;
                    end
                    if (op >= OP_CLOSE && !b[7])
                    begin
                        fault = FAULT_CTRL_FRAG;
                        return;
                    end
                    opcode = op;
                    fin    = b[7];
                    st     = ST_LEN;
                end
            endcase
            due_bytes.insert(due_bytes.size(), o);
        endfunction

        function void check_out(input logic [7:0] data);
            logic [7:0] want;
            if (due_bytes.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10) $display("out beat %h with none expected", data);
                return;
            end
            want = due_bytes.pop_front();
            if (data !== want)
            begin
                bad_count++;
                if (bad_count <= 10) $display("out beat: expected %h, got %h", want, data);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_data;

    deframe_tracker tracker;
    logic [7:0]     body_q[$];
    logic           cur_mode;
    int             src_idle;
    int             sink_idle;
    int             sent_count;
    int             cycle_count;
    bit             hold_req;

    websocket_frame_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("websocket_frame_deframer: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) tracker.take_in(s_tdata);
        if (rst_n && m_tvalid && m_tready) tracker.check_out(m_tdata);
        if (rst_n && cfg_valid && cfg_ready) tracker.server_mode = cfg_data[0];
    end

    // receiver side; a hold request stalls it for a long stretch
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    function automatic void add_body(input logic [7:0] b);
        body_q.insert(body_q.size(), b);
    endfunction

    task automatic push_byte(input logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
    endtask

    // header, extended length, key if masked, then body_q, masked with the key if masked
    task automatic emit_frame(input logic fin, input logic [3:0] op, input logic [63:0] len,
                              input int form, input logic masked, input logic [31:0] key);
        int         i;
        logic [7:0] pb;
        push_byte({fin, 3'b000, op});
        case (form)
            FORM_7:
                push_byte({masked, len[6:0]});
            FORM_16:
            begin
                push_byte({masked, LEN_EXT16});
                push_byte(len[15:8]);
                push_byte(len[7:0]);
            end
            default:
            begin
                push_byte({masked, LEN_EXT64});
                for (i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
        for (i = 0; i < body_q.size(); i++)
        begin
            pb = masked ? (body_q[i] ^ key[8 * (3 - (i % 4)) +: 8]) : body_q[i];
            push_byte(pb);
        end
    endtask

    // encode any code point in k bytes, overlong and out-of-range forms included
    task automatic add_char(input int k, input logic [20:0] cp);
        case (k)
            1:
                add_body({1'b0, cp[6:0]});
            2:
            begin
                add_body({3'b110, cp[10:6]});
                add_body({2'b10, cp[5:0]});
            end
            3:
            begin
                add_body({4'b1110, cp[15:12]});
                add_body({2'b10, cp[11:6]});
                add_body({2'b10, cp[5:0]});
            end
            default:
            begin
                add_body({5'b11110, cp[20:18]});
                add_body({2'b10, cp[17:12]});
                add_body({2'b10, cp[11:6]});
                add_body({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [20:0] rand_cp(input int k);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case (k)
            1:
            begin
                lo = 21'h0;
                hi = 21'h7F;
            end
            2:
            begin
                lo = 21'h80;
                hi = 21'h7FF;
            end
            3:
            begin
                lo = 21'h800;
                hi = 21'hFFFF;
            end
            default:
            begin
                lo = 21'h10000;
                hi = 21'h10FFFF;
            end
        endcase
        case ($urandom_range(0, 7))
            0:       cp = lo;
            1:       cp = hi;
            default: cp = 21'($urandom_range(hi, lo));
        endcase
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h1000;
        return cp;
    endfunction

    task automatic utf8_fill(input int n);
        int k;
        while (n > 0)
        begin
            k = $urandom_range(1, (n < 4) ? n : 4);
            add_char(k, rand_cp(k));
            n -= k;
        end
    endtask

    function automatic int pick_form(input int len);
        if (len > CTRL_MAX_LEN || $urandom_range(0, 5) == 0)
            return $urandom_range(FORM_16, FORM_64);
        return FORM_7;
    endfunction

    task automatic random_frame();
        int         pick;
        int         len;
        int         i;
        logic       fin;
        logic [3:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_TEXT;
        else if (pick < 65) op = OP_BIN;
        else if (pick < 78) op = OP_CONT;
        else if (pick < 86) op = OP_CLOSE;
        else if (pick < 93) op = OP_PING;
        else                op = OP_PONG;
        if (op >= OP_CLOSE)
        begin
            fin = 1'b1;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, CTRL_MAX_LEN)
                                               : $urandom_range(0, 6);
        end
        else
        begin
            fin  = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)      len = 0;
            else if (pick < 17) len = $urandom_range(1, 20);
            else if (pick < 19) len = $urandom_range(126, 300);
            else                len = $urandom_range(21, CTRL_MAX_LEN);
        end
        body_q = {};
        if (op == OP_TEXT && fin)
            utf8_fill(len);
        else
            for (i = 0; i < len; i++) add_body(8'($urandom_range(0, 255)));
        emit_frame(fin, op, 64'(len), pick_form(len), cur_mode, $urandom);
    endtask

    task automatic run_random(input int count);
        int start;
        start = sent_count;
        while (sent_count - start < count) random_frame();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_mode = v;
    endtask

    // end the stream with one violation of a random kind, then trailing noise
    task automatic break_stream();
        int          kind;
        int          k;
        logic [63:0] len;
        logic        huge;
        body_q = {};
        kind   = $urandom_range(0, 10);
        huge   = $urandom_range(0, 1);
        if (kind >= 5) utf8_fill($urandom_range(0, 5));
        case (kind)
            0:
                push_byte({1'b1, 3'($urandom_range(1, 7)), OP_TEXT});
            1:
                push_byte({1'($urandom_range(0, 1)), 3'b000,
                           ($urandom_range(0, 1) == 0) ? 4'($urandom_range(3, 7))
                                                       : 4'($urandom_range(11, 15))});
            2:
                push_byte({1'b0, 3'b000, 4'($urandom_range(OP_CLOSE, OP_PONG))});
            3:
            begin
                push_byte({1'b1, 3'b000, OP_BIN});
                push_byte({~cur_mode, 7'($urandom_range(0, CTRL_MAX_LEN))});
            end
            4:
                emit_frame(1'b1, 4'($urandom_range(OP_CLOSE, OP_PONG)),
                           64'($urandom_range(126, 65535)), $urandom_range(FORM_16, FORM_64),
                           cur_mode, $urandom);
            5:
                add_body(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                     : 8'($urandom_range(8'hF8, 8'hFF)));
            6:
            begin
                add_body(8'($urandom_range(8'hC2, 8'hDF)));
                add_body(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 8'h7F))
                                                     : 8'($urandom_range(8'hC0, 8'hFF)));
            end
            7:
            begin
                k = $urandom_range(2, 4);
                add_char(k, (k == 2) ? 21'($urandom_range(0, 21'h7F)) :
                            (k == 3) ? 21'($urandom_range(0, 21'h7FF)) :
                                       21'($urandom_range(0, 21'hFFFF)));
            end
            8:
                add_char(3, 21'($urandom_range(21'hD800, 21'hDFFF)));
            9:
                add_char(4, 21'($urandom_range(21'h110000, 21'h1FFFFF)));
            default:
            begin
                k = $urandom_range(2, 4);
                add_char(k, rand_cp(k));
                repeat ($urandom_range(1, k - 1)) void'(body_q.pop_back());
                huge = 1'b0;
            end
        endcase
        if (kind >= 5)
        begin
            len = huge ? {1'b1, 31'($urandom), 32'($urandom)} : 64'(body_q.size());
            emit_frame(1'b1, OP_TEXT, len, huge ? FORM_64 : pick_form(int'(len)),
                       cur_mode, $urandom);
        end
        repeat (16) push_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        tracker   = new;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        cur_mode  = 1'b1;
        src_idle  = 0;
        sink_idle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-length non-final text, then a continuation with a padded 16-bit length
        body_q = {};
        emit_frame(1'b0, OP_TEXT, 64'd0, FORM_7, cur_mode, 32'hFFFF_FFFF);
        body_q = {8'hFF, 8'hC0};
        emit_frame(1'b1, OP_CONT, 64'd2, FORM_16, cur_mode, 32'h0000_0000);
        body_q = {};
        emit_frame(1'b1, OP_PING, 64'd0, FORM_7, cur_mode, 32'h1234_5678);
        add_char(1, 21'h7F);
        add_char(3, 21'hD7FF);
        add_char(3, 21'hE000);
        add_char(4, 21'h10FFFF);
        emit_frame(1'b1, OP_TEXT, 64'(body_q.size()), FORM_7, cur_mode, 32'hA55A_0FF0);
        body_q = {};
        emit_frame(1'b1, OP_CLOSE, 64'd0, FORM_7, cur_mode, $urandom);
        emit_frame(1'b1, OP_PONG, 64'd0, FORM_7, cur_mode, $urandom);

        src_idle  = 12;
        sink_idle = 70;
        write_mode(1'b0);
        run_random(250);

        src_idle  = 70;
        sink_idle = 12;
        write_mode(1'b1);
        run_random(250);

        src_idle  = 0;
        sink_idle = 0;
        write_mode(1'b0);
        hold_req = 1'b1;
        run_random(250);

        write_mode(1'($urandom_range(0, 1)));
        break_stream();
        drain();

        if (tracker.bad_count == 0 && tracker.pending() == 0)
            $display("websocket_frame_deframer: match");
        else
            $display("websocket_frame_deframer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_utf8.sv
hw/rtl/wsd_parser.sv
hw/rtl/websocket_frame_deframer.sv
dv/websocket_frame_deframer_tb.sv
